>>> rtl/core/arp_address_cache_assert.svh
// Assertion macros for the address-resolution cache.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ARP_ADDRESS_CACHE_ASSERT_SVH
`define ARP_ADDRESS_CACHE_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define ARPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/arpc_pkg.sv
// Shared types and constants for the address-resolution cache.
// No dependencies; used by every module of the block.
package arpc_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 3;

  // Stream payload widths, rounded up to whole bytes
  localparam int unsigned S_TDATA_W = ((IP_W + MAC_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((MAC_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  // Table write port
  typedef struct packed {
    logic             ip_we;
    logic             mac_we;
    logic [IDX_W-1:0] addr;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_wr_t;

  // Registered table read data
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_rd_t;

endpackage

>>> rtl/core/arpc_table.sv
// Entry storage: address and hardware-address memories, one write port,
// one registered read port. Depends on arpc_pkg.
module arpc_table import arpc_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  arpc_wr_t         wr_i,
  output arpc_rd_t         rd_o
);

  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];
  arpc_rd_t         rd_q;

  // Writes; an update touches only the hardware address
  always_ff @(posedge clk_i) begin
    if (wr_i.ip_we) begin
      ip_mem[wr_i.addr] <= wr_i.ip;
    end
    if (wr_i.mac_we) begin
      mac_mem[wr_i.addr] <= wr_i.mac;
    end
  end

  // Registered read, one entry per cycle
  always_ff @(posedge clk_i) begin
    rd_q.ip  <= ip_mem[rd_addr_i];
    rd_q.mac <= mac_mem[rd_addr_i];
  end

  assign rd_o = rd_q;

endmodule

>>> rtl/core/arpc_ctrl.sv
// Command sequencer: linear scan with one shared address comparator,
// table write-back, entry count and the result register. Depends on arpc_pkg.
`include "arp_address_cache_assert.svh"

module arpc_ctrl import arpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [CMD_W-1:0]  s_cmd_i,
  input  logic [IP_W-1:0]   s_ip_i,
  input  logic [MAC_W-1:0]  s_mac_i,
  // result side
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [STAT_W-1:0] m_status_o,
  output logic [MAC_W-1:0]  m_mac_o,
  output logic [CNT_W-1:0]  m_count_o,
  // table port
  output logic [IDX_W-1:0]  rd_addr_o,
  output arpc_wr_t          wr_o,
  input  arpc_rd_t          rd_i
);

  state_e             st_q, st_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [IP_W-1:0]    ip_q, ip_d;
  logic [MAC_W-1:0]   mac_q, mac_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               dv_q, dv_d;
  logic [IDX_W-1:0]   cmp_q, cmp_d;
  logic [STAT_W-1:0]  res_stat_q, res_stat_d;
  logic [MAC_W-1:0]   res_mac_q, res_mac_d;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic [MAC_W-1:0]   out_mac_q, out_mac_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic s_fire;
  logic out_free;
  logic match;
  logic scan_done;
  logic has_room;

  assign s_fire    = s_valid_i && s_ready_o;
  assign out_free  = !out_valid_q || m_ready_i;
  // shared comparator on the entry read last cycle
  assign match     = dv_q && (rd_i.ip == ip_q);
  assign scan_done = match || (iss_q == used_q);
  assign has_room  = used_q < CNT_W'(ENTRIES);

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (s_fire) begin
          if (s_cmd_i == CMD_LOOKUP || s_cmd_i == CMD_ADD) begin
            st_d = S_SCAN;
          end else begin
            st_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          st_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Handshake and table control
  always_comb begin
    s_ready_o  = (st_q == S_IDLE);
    rd_addr_o  = iss_q[IDX_W-1:0];
    wr_o.ip_we  = 1'b0;
    wr_o.mac_we = 1'b0;
    wr_o.addr   = used_q[IDX_W-1:0];
    wr_o.ip     = ip_q;
    wr_o.mac    = mac_q;
    if (st_q == S_SCAN && scan_done && cmd_q == CMD_ADD) begin
      if (match) begin
        wr_o.mac_we = 1'b1;
        wr_o.addr   = cmp_q;
      end else if (has_room) begin
        wr_o.ip_we  = 1'b1;
        wr_o.mac_we = 1'b1;
      end
    end
  end

  // Datapath registers
  always_comb begin
    cmd_d       = cmd_q;
    ip_d        = ip_q;
    mac_d       = mac_q;
    used_d      = used_q;
    iss_d       = iss_q;
    dv_d        = dv_q;
    cmp_d       = cmp_q;
    res_stat_d  = res_stat_q;
    res_mac_d   = res_mac_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_stat_d  = out_stat_q;
    out_mac_d   = out_mac_q;
    out_cnt_d   = out_cnt_q;
    case (st_q)
      S_IDLE: begin
        if (s_fire) begin
          cmd_d     = s_cmd_i;
          ip_d      = s_ip_i;
          mac_d     = s_mac_i;
          iss_d     = '0;
          dv_d      = 1'b0;
          res_mac_d = '0;
          if (s_cmd_i == CMD_CLEAR) begin
            used_d     = '0;
            res_stat_d = ST_CLEARED;
          end else begin
            res_stat_d = ST_MISS;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while entries remain
        if (iss_q != used_q) begin
          iss_d = iss_q + CNT_W'(1);
          dv_d  = 1'b1;
          cmp_d = iss_q[IDX_W-1:0];
        end else begin
          dv_d = 1'b0;
        end
        if (scan_done) begin
          dv_d = 1'b0;
          if (cmd_q == CMD_LOOKUP) begin
            res_stat_d = match ? ST_HIT : ST_MISS;
            res_mac_d  = match ? rd_i.mac : '0;
          end else if (match) begin
            res_stat_d = ST_UPDATED;
          end else if (has_room) begin
            res_stat_d = ST_INSERTED;
            used_d     = used_q + CNT_W'(1);
          end else begin
            res_stat_d = ST_FULL;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_mac_d   = res_mac_q;
          out_cnt_d   = used_q;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      used_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      used_q      <= used_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    ip_q       <= ip_d;
    mac_q      <= mac_d;
    iss_q      <= iss_d;
    cmp_q      <= cmp_d;
    res_stat_q <= res_stat_d;
    res_mac_q  <= res_mac_d;
    out_stat_q <= out_stat_d;
    out_mac_q  <= out_mac_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_stat_q;
  assign m_mac_o    = out_mac_q;
  assign m_count_o  = out_cnt_q;

  // Checks
  `ARPC_ASSERT(a_used_bound, used_q <= CNT_W'(ENTRIES), "entry count above table depth")
  `ARPC_ASSERT_IMP(a_cmp_in_range, dv_q, CNT_W'(cmp_q) < used_q, "compare past used entries")
  `ARPC_ASSERT_IMP(a_insert_at_end, wr_o.ip_we,
    (wr_o.addr == used_q[IDX_W-1:0]) && has_room, "insert not at table end")
  `ARPC_ASSERT_IMP(a_count_grows_on_insert, used_q > $past(used_q), $past(wr_o.ip_we),
    "entry count grew without an insert")

endmodule

>>> rtl/core/arp_address_cache.sv
// Address-resolution cache, top level: stream ports, payload packing,
// sequencer and entry memory. Depends on arpc_pkg, arpc_ctrl, arpc_table.
//
// Usage:
//   Requests enter on s_axis: tuser carries the command (lookup, add,
//   clear), tdata the IPv4 address and the hardware address. Each request
//   gives exactly one result on m_axis: tuser carries the status, tdata the
//   matched hardware address and the used-entry count.
//   Lookup and add scan the used entries in fill order, one compare per
//   cycle against the memory's registered read port, until a match or the
//   last used entry; clear and unused codes skip the scan.
//   One request is in work at a time: s_axis_tready is high only while the
//   sequencer is idle, so a new request waits until the last one has passed
//   the scan and handed its result to the output register.
//   The result sits in an output register; a new request is taken while it
//   waits, and a stalled receiver holds only the next result's hand-off.
//   Reset empties the table at once (count to zero); no clearing pass.
module arp_address_cache import arpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // mac_out[47:0], entry_count[56:48], zero
  output logic [STAT_W-1:0]    m_axis_tuser   // status[2:0]
);

  logic [IP_W-1:0]  s_ip;
  logic [MAC_W-1:0] s_mac;
  logic [MAC_W-1:0] m_mac;
  logic [CNT_W-1:0] m_count;
  logic [IDX_W-1:0] rd_addr;
  arpc_wr_t         wr;
  arpc_rd_t         rd;

  // Unpack request fields
  assign s_ip  = s_axis_tdata[IP_W-1:0];
  assign s_mac = s_axis_tdata[IP_W +: MAC_W];

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_cmd_i    (s_axis_tuser),
    .s_ip_i     (s_ip),
    .s_mac_i    (s_mac),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_status_o (m_axis_tuser),
    .m_mac_o    (m_mac),
    .m_count_o  (m_count),
    .rd_addr_o  (rd_addr),
    .wr_o       (wr),
    .rd_i       (rd)
  );

  arpc_table u_table (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  // Pack result fields, zero fill to a whole byte
  assign m_axis_tdata = {{(M_TDATA_W - MAC_W - CNT_W){1'b0}}, m_count, m_mac};

endmodule

>>> tb/arp_cache_checker.sv
// Checker for the address-resolution cache: watches both stream channels,
// predicts every result from its own copy of the table and compares them.
// Depends on arpc_pkg for widths, commands and status codes.
`timescale 1ns / 1ps

module arp_cache_checker import arpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,  // mac_out[47:0], entry_count[56:48]
  input  logic [STAT_W-1:0]    m_axis_tuser,  // status[2:0]
  output int                   mismatches_o,
  output int                   results_left_o,
  output int                   results_seen_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MAC_W-1:0]  mac;
    logic [CNT_W-1:0]  count;
  } cache_result_t;

  // Own copy of the table, filled in order
  logic [IP_W-1:0]  cached_ip [ENTRIES];
  logic [MAC_W-1:0] cached_mac[ENTRIES];
  int               cached_count;

  cache_result_t expected_results[$];
  cache_result_t expected, observed;
  int            mismatches;
  int            results_seen;

  assign mismatches_o   = mismatches;
  assign results_seen_o = results_seen;

  // First used slot holding the address, -1 when absent
  function automatic int find_slot(logic [IP_W-1:0] ip);
    for (int i = 0; i < cached_count; i++) begin
      if (cached_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  // Applies one request to the table copy and returns the answer it gives
  function automatic cache_result_t resolve_request(logic [CMD_W-1:0] cmd,
                                                    logic [IP_W-1:0] ip,
                                                    logic [MAC_W-1:0] mac);
    cache_result_t res;
    int slot;
    res.status = ST_MISS;
    res.mac    = '0;
    case (cmd)
      CMD_LOOKUP: begin
        slot = find_slot(ip);
        if (slot >= 0) begin
          res.status = ST_HIT;
          res.mac    = cached_mac[slot];
        end
      end
      CMD_ADD: begin
        slot = find_slot(ip);
        if (slot >= 0) begin
          cached_mac[slot] = mac;
          res.status       = ST_UPDATED;
        end else if (cached_count < ENTRIES) begin
          cached_ip[cached_count]  = ip;
          cached_mac[cached_count] = mac;
          cached_count++;
          res.status = ST_INSERTED;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_CLEAR: begin
        cached_count = 0;
        res.status   = ST_CLEARED;
      end
      default: ;  // unused code answers a miss, table untouched
    endcase
    res.count = CNT_W'(cached_count);
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Results are matched first, so a stray result is not hidden by a request
  // taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_count = 0;
      expected_results.delete();
      mismatches     = 0;
      results_seen   = 0;
      results_left_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        observed.status = m_axis_tuser;
        observed.mac    = m_axis_tdata[MAC_W-1:0];
        observed.count  = m_axis_tdata[MAC_W +: CNT_W];
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d", observed.status);
          mismatches++;
        end else begin
          expected = expected_results.pop_front();
          check_field("status", expected.status, observed.status);
          check_field("mac_out", expected.mac, observed.mac);
          check_field("entry_count", expected.count, observed.count);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(resolve_request(s_axis_tuser,
                                                   s_axis_tdata[IP_W-1:0],
                                                   s_axis_tdata[IP_W +: MAC_W]));
      end
      results_left_o <= expected_results.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the address-resolution cache testbench: clock, reset, request
// stimulus and receiver stalls; the verdict comes from arp_cache_checker.
// Depends on arpc_pkg, arp_address_cache and arp_cache_checker.
`timescale 1ns / 1ps

module testbench;
  import arpc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_REQUESTS = 195;
  localparam int SETTLE_CYCLES  = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = CMD_LOOKUP;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;

  int mismatches, results_left, results_seen;
  int tx_idle_pct, rx_idle_pct;

  // Addresses the table holds now, for steering requests to hits and updates
  logic [IP_W-1:0] stored_ips[$];
  bit              ip_known[bit [IP_W-1:0]];

  int lookups_sent, adds_sent, clears_sent, unused_sent, drops_sent, peak_fill;

  arp_address_cache dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  arp_cache_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches_o   (mismatches),
    .results_left_o (results_left),
    .results_seen_o (results_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  function automatic logic [IP_W-1:0] fresh_ip();
    logic [IP_W-1:0] ip;
    do ip = $urandom; while (ip_known.exists(ip));
    return ip;
  endfunction

  function automatic logic [IP_W-1:0] known_ip();
    return stored_ips[$urandom_range(stored_ips.size() - 1)];
  endfunction

  // Drives one request, with random idle cycles ahead of it, and waits for
  // its handshake; tvalid stays high afterwards
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                              logic [MAC_W-1:0] mac);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({mac, ip});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    // keep the steering list in step with the table
    case (cmd)
      CMD_LOOKUP: lookups_sent++;
      CMD_ADD: begin
        adds_sent++;
        if (!ip_known.exists(ip)) begin
          if (stored_ips.size() < ENTRIES) begin
            stored_ips.push_back(ip);
            ip_known[ip] = 1'b1;
            if (stored_ips.size() > peak_fill) peak_fill = stored_ips.size();
          end else begin
            drops_sent++;
          end
        end
      end
      CMD_CLEAR: begin
        clears_sent++;
        stored_ips.delete();
        ip_known.delete();
      end
      default: unused_sent++;
    endcase
  endtask

  // Sender holds off until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_left != 0);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35 && stored_ips.size() != 0)
      send_request(CMD_LOOKUP, known_ip(), random_mac());
    else if (pick < 45)
      send_request(CMD_LOOKUP, fresh_ip(), random_mac());
    else if (pick < 60 && stored_ips.size() != 0)
      send_request(CMD_ADD, known_ip(), random_mac());
    else if (pick < 96)
      send_request(CMD_ADD, fresh_ip(), random_mac());
    else if (pick < 99)
      send_request(CMD_UNUSED, $urandom, random_mac());
    else
      send_request(CMD_CLEAR, $urandom, random_mac());
  endtask

  // Empty the table, fill it to the last entry with hits and updates mixed
  // in, hit and update that last entry, then push new addresses against the full table
  task automatic fill_table();
    send_request(CMD_CLEAR, $urandom, random_mac());
    while (stored_ips.size() < ENTRIES) begin
      if ($urandom_range(3) == 0 && stored_ips.size() != 0)
        send_request($urandom_range(1) ? CMD_ADD : CMD_LOOKUP, known_ip(), random_mac());
      else
        send_request(CMD_ADD, fresh_ip(), random_mac());
    end
    send_request(CMD_LOOKUP, stored_ips[ENTRIES-1], random_mac());
    send_request(CMD_ADD, stored_ips[ENTRIES-1], random_mac());
    repeat (4) send_request(CMD_ADD, fresh_ip(), random_mac());
    send_request(CMD_LOOKUP, fresh_ip(), random_mac());
  endtask

  initial begin
    tx_idle_pct = 22;
    rx_idle_pct = 64;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, field extremes, updates at both ends, unused code
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_ADD, '1, '1);
    send_request(CMD_ADD, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
    send_request(CMD_ADD, 32'h5555_5555, 48'h5555_5555_5555);
    send_request(CMD_LOOKUP, '0, '1);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_LOOKUP, 32'h5555_5555, '0);
    send_request(CMD_ADD, '0, '1);
    send_request(CMD_ADD, '1, '0);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_LOOKUP, 32'h1234_5678, '0);
    send_request(CMD_UNUSED, 32'hAAAA_AAAA, '1);
    send_request(CMD_UNUSED, '0, '0);
    send_request(CMD_CLEAR, '1, '1);
    send_request(CMD_LOOKUP, 32'hAAAA_AAAA, '0);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_ADD, 32'hAAAA_AAAA, 48'h1234_5678_9ABC);
    send_request(CMD_LOOKUP, 32'hAAAA_AAAA, '0);
    drain_results();

    // Random: sender-light idling, then receiver-light after a table fill, then none
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 64 : 0;
      rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 22 : 0;
      if (phase == 1) fill_table();
      repeat (PHASE_REQUESTS) send_random_request();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d lookups, %0d adds, %0d clears, %0d unused codes; %0d results checked",
             lookups_sent, adds_sent, clears_sent, unused_sent, results_seen);
    $display("Table reached %0d entries; %0d adds hit a full table", peak_fill, drops_sent);
    if (mismatches == 0 && results_left == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> arp_address_cache.f
+incdir+rtl/core
rtl/core/arpc_pkg.sv
rtl/core/arpc_table.sv
rtl/core/arpc_ctrl.sv
rtl/core/arp_address_cache.sv
tb/arp_cache_checker.sv
tb/testbench.sv
